FILE: design/prsmt_pkg.sv
// shared types and constants for the prioritized replay sum/min tree
package prsmt_pkg;
	localparam int CAPACITY = 1024;
	localparam logic [1:0] REQ_INSERT  = 2'd0;
	localparam logic [1:0] REQ_UPDATE  = 2'd1;
	localparam logic [1:0] REQ_SAMPLE  = 2'd2;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_STALE = 2'd1;
	localparam logic [1:0] ST_FEW   = 2'd2;
	localparam logic [1:0] CFG_MIN_SAMPLES = 2'd0;
	localparam logic [31:0] MIN_INF = 32'hFFFF_FFFF;
	localparam int IN_W  = 104;
	localparam int OUT_W = 184;
	typedef struct packed {
		logic [15:0] search_fraction;
		logic [47:0] target_index;
		logic [31:0] priority_req;
		logic [1:0]  req_type;
	} req_t;
	typedef struct packed {
		logic [1:0]  status;
		logic [10:0] fill_count;
		logic [31:0] root_min;
		logic [47:0] root_sum;
		logic [31:0] leaf_priority;
		logic [47:0] global_out;
		logic [9:0]  slot;
	} res_t;
endpackage

FILE: design/prsmt_ram.sv
// generic single-port-write, single-port-read ram with registered read
module prsmt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: design/prioritized_replay_sum_min_tree.sv
// insert and fresh update: write the leaf and each parent up to the root, then read it back
// sample walks down to a leaf; stale update reads its leaf; short sample, unknown go to output
// result held in an output register; s_tready low while a request is in work or waits for it
// after reset a clearing pass writes all 2*CAPACITY nodes of both trees before the first beat
// arst_n clears control state, write count and min_samples (to 1)
module prioritized_replay_sum_min_tree (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// req_type, priority_req, target_index, search_fraction
	input  logic [prsmt_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// slot, global_out, leaf_priority, total, minimum, fill_count, status
	output logic [prsmt_pkg::OUT_W-1:0] m_tdata,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [1:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	localparam int CAPACITY = prsmt_pkg::CAPACITY;
	localparam int LW = $clog2(CAPACITY);
	localparam int AW = LW + 1;
	localparam int NODES = 2 * CAPACITY;
	localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_UPRD = 4'd2, S_UPWR = 4'd3,
		S_SMRD = 4'd4, S_SMST = 4'd5, S_LEAF = 4'd6, S_LEAF2 = 4'd7, S_OUT = 4'd8,
		S_PREF = 4'd9;

	logic [3:0] state_q;
	logic [AW-1:0] idx_q, clr_q;
	logic [47:0] wc_q, tot_q, acc_q, pref_q;
	logic [31:0] min_q, vmin_q;
	logic [10:0] msamp_q;
	prsmt_pkg::req_t req_q;
	prsmt_pkg::res_t res_q;
	logic out_v_q;
	logic [LW-1:0] slot_q;
	logic [47:0] glob_q;
	logic [31:0] leaf_q;
	logic [1:0] st_q;

	logic s_we, m_we;
	logic [AW-1:0] waddr, raddr;
	logic [47:0] s_wd, s_rd;
	logic [31:0] m_wd, m_rd;

	prsmt_ram #(.WIDTH(48), .DEPTH(NODES)) u_sum (.clk(clk), .we(s_we), .waddr(waddr),
		.wdata(s_wd), .raddr(raddr), .rdata(s_rd));
	prsmt_ram #(.WIDTH(32), .DEPTH(NODES)) u_min (.clk(clk), .we(m_we), .waddr(waddr),
		.wdata(m_wd), .raddr(raddr), .rdata(m_rd));

	prsmt_pkg::req_t rin;
	assign rin = prsmt_pkg::req_t'(s_tdata[97:0]);
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata = {1'b0, res_q};
	assign pready = 1'b1;
	assign prdata = {21'd0, msamp_q};

	logic [47:0] oldest, wcn, fillw;
	logic [10:0] fill;
	assign oldest = (wc_q > 48'(CAPACITY)) ? wc_q - 48'(CAPACITY) : 48'd0;
	assign fillw = (wc_q < 48'(CAPACITY)) ? wc_q : 48'(CAPACITY);
	assign fill = fillw[10:0];
	assign wcn = wc_q + 48'd1;

	logic [31:0] mn;
	logic [47:0] ssum;
	assign mn = (m_rd < vmin_q) ? m_rd : vmin_q;
	assign ssum = acc_q + s_rd;
	logic [63:0] prod;
	assign prod = 64'(req_q.search_fraction) * 64'(tot_q);

	always_comb begin
		s_we = 1'b0; m_we = 1'b0; waddr = idx_q; raddr = idx_q ^ AW'(1);
		s_wd = acc_q; m_wd = vmin_q;
		unique case (state_q) inside
			S_CLR: begin
				s_we = 1'b1; m_we = 1'b1; waddr = clr_q; s_wd = '0; m_wd = prsmt_pkg::MIN_INF;
			end
			S_UPRD: begin
				s_we = 1'b1; m_we = 1'b1;
			end
			S_UPWR: begin
				s_we = 1'b1; m_we = 1'b1; waddr = idx_q >> 1; s_wd = ssum; m_wd = mn;
				raddr = (idx_q >> 1) ^ AW'(1);
			end
			S_SMRD, S_SMST: raddr = idx_q << 1;
			S_LEAF: raddr = {1'b1, slot_q};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR; clr_q <= '0; wc_q <= '0; msamp_q <= 11'd1; out_v_q <= 1'b0;
			tot_q <= '0; min_q <= prsmt_pkg::MIN_INF;
		end else begin
			if (psel && penable && pwrite && paddr == prsmt_pkg::CFG_MIN_SAMPLES)
				msamp_q <= pwdata[10:0];
			if (state_q == S_OUT && (!out_v_q || m_tready)) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NODES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (s_tvalid && s_tready) begin
					req_q <= rin; leaf_q <= '0;
					acc_q <= 48'(rin.priority_req); vmin_q <= rin.priority_req;
					if (rin.req_type == prsmt_pkg::REQ_INSERT) begin
						st_q <= prsmt_pkg::ST_DONE;
						slot_q <= wc_q[LW-1:0]; idx_q <= {1'b1, wc_q[LW-1:0]};
						glob_q <= wc_q; wc_q <= wcn; state_q <= S_UPRD;
					end else if (rin.req_type == prsmt_pkg::REQ_UPDATE) begin
						slot_q <= rin.target_index[LW-1:0];
						idx_q <= {1'b1, rin.target_index[LW-1:0]};
						glob_q <= rin.target_index;
						if (rin.target_index >= oldest) begin
							st_q <= prsmt_pkg::ST_DONE; state_q <= S_UPRD;
						end else begin
							st_q <= prsmt_pkg::ST_STALE; state_q <= S_LEAF;
						end
					end else if (rin.req_type == prsmt_pkg::REQ_SAMPLE) begin
						slot_q <= '0; glob_q <= '0;
						if ({1'b0, fill} < {1'b0, msamp_q}) begin
							st_q <= prsmt_pkg::ST_FEW; state_q <= S_OUT;
						end else begin
							st_q <= prsmt_pkg::ST_DONE; idx_q <= AW'(1); state_q <= S_PREF;
						end
					end else begin
						st_q <= prsmt_pkg::ST_DONE; slot_q <= '0; glob_q <= '0;
						state_q <= S_OUT;
					end
				end
				S_PREF: begin
					pref_q <= prod[63:16]; state_q <= S_SMRD;
				end
				S_UPRD: state_q <= S_UPWR;
				S_UPWR: begin
					acc_q <= ssum; vmin_q <= mn; idx_q <= idx_q >> 1;
					if ((idx_q >> 1) == AW'(1)) begin
						tot_q <= ssum; min_q <= mn; state_q <= S_LEAF;
					end else state_q <= S_UPWR;
				end
				S_SMRD: state_q <= S_SMST;
				S_SMST: begin
					if (s_rd > pref_q) idx_q <= idx_q << 1;
					else begin
						pref_q <= pref_q - s_rd; idx_q <= (idx_q << 1) | AW'(1);
					end
					if (idx_q >= AW'(CAPACITY / 2)) begin
						state_q <= S_LEAF;
						slot_q <= (s_rd > pref_q) ? {idx_q[LW-2:0], 1'b0} : {idx_q[LW-2:0], 1'b1};
					end else state_q <= S_SMRD;
				end
				S_LEAF: state_q <= S_LEAF2;
				S_LEAF2: begin
					leaf_q <= s_rd[31:0];
					if (req_q.req_type == prsmt_pkg::REQ_SAMPLE) begin
						if ({wc_q[47:LW], slot_q} >= wc_q)
							glob_q <= {wc_q[47:LW], slot_q} - 48'(CAPACITY);
						else glob_q <= {wc_q[47:LW], slot_q};
					end
					state_q <= S_OUT;
				end
				S_OUT: if (!out_v_q || m_tready) begin
					res_q.slot <= 10'(slot_q); res_q.global_out <= glob_q;
					res_q.leaf_priority <= leaf_q;
					res_q.root_sum <= tot_q; res_q.root_min <= min_q;
					res_q.fill_count <= fill; res_q.status <= st_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ap_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == S_IDLE) else $error("ready outside idle");
	ap_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT |=> out_v_q) else $error("result not raised");
	ap_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
endmodule

FILE: tb/tb_prsmt_checker.sv
`timescale 1ns / 1ps
// checker: predicts the sum/min tree results and compares every output beat
module tb_prsmt_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [103:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [183:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [1:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           outstanding,
	output int           errors
);
	localparam int CAPACITY = prsmt_pkg::CAPACITY;
	localparam int NODE_CNT = 2 * CAPACITY;
	localparam logic [47:0] CAP48 = 48'(CAPACITY);

	logic [47:0] sum_model [NODE_CNT];
	logic [31:0] min_model [NODE_CNT];
	logic [47:0] entries_written;
	logic [10:0] serve_threshold;
	prsmt_pkg::res_t expected_q [$];

	assign outstanding = expected_q.size();

	function automatic logic [10:0] fill_level();
		return (entries_written < CAP48) ? entries_written[10:0] : 11'(CAPACITY);
	endfunction

	function automatic void write_leaf(int unsigned slot_idx, logic [31:0] prio);
		int unsigned n;
		n = slot_idx + CAPACITY;
		sum_model[n] = {16'd0, prio};
		min_model[n] = prio;
		while (n > 1) begin
			sum_model[n >> 1] = sum_model[n] + sum_model[n ^ 1];
			min_model[n >> 1] = (min_model[n] < min_model[n ^ 1]) ? min_model[n] :
				min_model[n ^ 1];
			n = n >> 1;
		end
	endfunction

	function automatic prsmt_pkg::res_t predict_beat(logic [103:0] beat);
		prsmt_pkg::res_t r;
		logic [1:0]  kind;
		logic [31:0] prio;
		logic [47:0] target;
		logic [15:0] frac;
		logic [47:0] oldest;
		logic [63:0] prefix;
		logic [63:0] g;
		int unsigned n;
		kind   = beat[1:0];
		prio   = beat[33:2];
		target = beat[81:34];
		frac   = beat[97:82];
		r = '0;
		r.status = prsmt_pkg::ST_DONE;
		case (kind)
			prsmt_pkg::REQ_INSERT: begin
				r.slot = entries_written[9:0];
				r.global_out = entries_written;
				write_leaf(int'(entries_written % CAP48), prio);
				r.leaf_priority = prio;
				entries_written = entries_written + 48'd1;
			end
			prsmt_pkg::REQ_UPDATE: begin
				oldest = (entries_written > CAP48) ? entries_written - CAP48 : '0;
				r.slot = target[9:0];
				r.global_out = target;
				if (target >= oldest)
					write_leaf(int'(target % CAP48), prio);
				else
					r.status = prsmt_pkg::ST_STALE;
				r.leaf_priority = sum_model[int'(target % CAP48) + CAPACITY][31:0];
			end
			prsmt_pkg::REQ_SAMPLE: begin
				if (fill_level() < serve_threshold) begin
					r.status = prsmt_pkg::ST_FEW;
				end else begin
					prefix = ({48'd0, frac} * {16'd0, sum_model[1]}) >> 16;
					n = 1;
					while (n < CAPACITY) begin
						if ({16'd0, sum_model[2 * n]} > prefix) begin
							n = 2 * n;
						end else begin
							prefix = prefix - {16'd0, sum_model[2 * n]};
							n = 2 * n + 1;
						end
					end
					r.slot = 10'(n - CAPACITY);
					r.leaf_priority = sum_model[n][31:0];
					g = 64'(n - CAPACITY) + {16'd0, entries_written - (entries_written % CAP48)};
					if (g >= {16'd0, entries_written})
						g = g - 64'(CAPACITY);
					r.global_out = g[47:0];
				end
			end
			default: ;
		endcase
		r.root_sum = sum_model[1];
		r.root_min = min_model[1];
		r.fill_count = fill_level();
		return r;
	endfunction

	always @(posedge clk) begin
		prsmt_pkg::res_t want;
		prsmt_pkg::res_t got;
		prsmt_pkg::res_t pred;
		if (!arst_n) begin
			for (int i = 0; i < NODE_CNT; i++) begin
				sum_model[i] = '0;
				min_model[i] = prsmt_pkg::MIN_INF;
			end
			entries_written = '0;
			serve_threshold <= 11'd1;
			expected_q.delete();
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == prsmt_pkg::CFG_MIN_SAMPLES)
				serve_threshold <= pwdata[10:0];
			if (s_tvalid && s_tready) begin
				pred = predict_beat(s_tdata);
				expected_q.insert(expected_q.size(), pred);
			end
			if (m_tvalid && m_tready) begin
				got = prsmt_pkg::res_t'(m_tdata[182:0]);
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result beat %h", m_tdata);
				end else begin
					want = expected_q.pop_front();
					if (got !== want || m_tdata[183] !== 1'b0) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch exp slot %0d glob %h leaf %h tot %h min %h fill %0d st %0d",
								want.slot, want.global_out, want.leaf_priority,
								want.root_sum, want.root_min, want.fill_count, want.status);
							$display("         got slot %0d glob %h leaf %h tot %h min %h fill %0d st %0d",
								got.slot, got.global_out, got.leaf_priority,
								got.root_sum, got.root_min, got.fill_count, got.status);
						end
					end
				end
			end
		end
	end
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, request stimulus, apb writes and the verdict
module tb_top;
	localparam int CYCLE_LIMIT = 400000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [183:0] m_tdata;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [1:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	int           outstanding;
	int           errors;
	int           cycles = 0;
	logic [47:0]  inserts_sent;
	int           burst_left;
	int           sent_count;
	logic         hold_off;

	prioritized_replay_sum_min_tree uut (.*);

	tb_prsmt_checker u_checker (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready), .outstanding(outstanding), .errors(errors)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver stall pattern: always ready, ready at random, or ready at odds of 1 in 4, mode chosen at random
	initial begin
		int mode;
		m_tready = 1'b0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (cycles % 64 == 0)
				mode = $urandom_range(0, 2);
			if (hold_off)
				m_tready <= 1'b0;
			else if (mode == 0)
				m_tready <= 1'b1;
			else if (mode == 1)
				m_tready <= 1'($urandom_range(0, 1));
			else
				m_tready <= ($urandom_range(0, 3) == 0);
		end
	end

	// one long receiver hold-off while requests keep coming
	initial begin
		hold_off = 1'b0;
		wait (sent_count >= 300);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic send_req(logic [1:0] kind, logic [31:0] prio, logic [47:0] target,
			logic [15:0] frac);
		logic rdy;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, frac, target, prio, kind};
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		sent_count++;
		if (kind == prsmt_pkg::REQ_INSERT)
			inserts_sent = inserts_sent + 48'd1;
	endtask

	task automatic write_min_samples(logic [10:0] value);
		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (60) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= prsmt_pkg::CFG_MIN_SAMPLES;
		pwdata <= {21'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(int count);
		int pick;
		logic [47:0] target;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 3) == 0)
				target = 48'({$urandom(), $urandom()});
			else
				target = inserts_sent - 48'($urandom_range(0, 1500));
			if (pick < 55)
				send_req(prsmt_pkg::REQ_INSERT, ($urandom_range(0, 3) == 0) ? $urandom() :
					32'($urandom_range(0, 1000)), target, 16'($urandom()));
			else if (pick < 75)
				send_req(prsmt_pkg::REQ_UPDATE, ($urandom_range(0, 7) == 0) ? 32'd0 :
					$urandom(), target, 16'($urandom()));
			else if (pick < 97)
				send_req(prsmt_pkg::REQ_SAMPLE, $urandom(), target, 16'($urandom()));
			else
				send_req(prsmt_pkg::REQ_UNKNOWN, $urandom(), target, 16'($urandom()));
		end
	endtask

	initial begin
		inserts_sent = '0;
		burst_left = 0;
		sent_count = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tree, extremes, far update targets and unknown requests
		send_req(prsmt_pkg::REQ_SAMPLE, '0, '0, 16'hFFFF);
		send_req(prsmt_pkg::REQ_UPDATE, 32'h1234, 48'd5, '0);
		send_req(prsmt_pkg::REQ_SAMPLE, '0, '0, 16'h0000);
		send_req(prsmt_pkg::REQ_INSERT, 32'd0, '0, '0);
		send_req(prsmt_pkg::REQ_INSERT, 32'hFFFF_FFFF, '0, '0);
		send_req(prsmt_pkg::REQ_INSERT, 32'd1, '0, '0);
		send_req(prsmt_pkg::REQ_SAMPLE, '0, '0, 16'h0000);
		send_req(prsmt_pkg::REQ_SAMPLE, '0, '0, 16'hFFFF);
		send_req(prsmt_pkg::REQ_SAMPLE, '0, '0, 16'h8000);
		send_req(prsmt_pkg::REQ_UPDATE, 32'hFFFF_FFFF, 48'd0, '0);
		send_req(prsmt_pkg::REQ_UPDATE, 32'd7, 48'hFFFF_FFFF_FFFF, '0);
		send_req(prsmt_pkg::REQ_UPDATE, 32'hAAAA_5555, 48'h5555_AAAA_5555, '0);
		send_req(prsmt_pkg::REQ_UNKNOWN, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
		send_req(prsmt_pkg::REQ_SAMPLE, '0, '0, 16'h0001);

		write_min_samples(11'd1024);
		send_req(prsmt_pkg::REQ_SAMPLE, '0, '0, 16'h4000);
		random_phase(300);
		write_min_samples(11'd1);
		random_phase(300);
		write_min_samples(11'($urandom_range(2, 1023)));
		random_phase(180);

		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (60) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

FILE: sim.f
design/prsmt_pkg.sv
design/prsmt_ram.sv
design/prioritized_replay_sum_min_tree.sv
tb/tb_prsmt_checker.sv
tb/tb_top.sv
